// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; clk and arst_n must exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== hw/rtl/mfm_pkg.sv =====
`default_nettype none
package mfm_pkg;

	localparam int NODE_W        = 20;
	localparam int CELL_W        = 20;
	localparam int FACE_CAPACITY = 4096;
	localparam int ID_W          = $clog2(FACE_CAPACITY);
	localparam int CNT_W         = $clog2(FACE_CAPACITY + 1);
	localparam int HASH_W        = $clog2(FACE_CAPACITY);
	localparam int HT_DEPTH      = 1 << HASH_W;
	localparam int FOLD_CHUNKS   = (2 + 4 * NODE_W + HASH_W - 1) / HASH_W;

	localparam logic [2:0] CT_PYRAMID = 3'd5;

	localparam logic [1:0] KIND_EDGE = 2'd0;
	localparam logic [1:0] KIND_QUAD = 2'd1;
	localparam logic [1:0] KIND_TRIA = 2'd2;

	localparam logic [2:0] FACE_TOTAL [6] = '{3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5};

	localparam logic [1:0] FACE_KIND_TAB [6][6] = '{
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
		'{2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0},
		'{2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd0},
		'{2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0}
	};

	localparam logic [2:0] LOCAL_TAB [6][6][4] = '{
		'{'{3'd0,3'd1,3'd0,3'd0}, '{3'd1,3'd2,3'd0,3'd0}, '{3'd2,3'd3,3'd0,3'd0},
		  '{3'd3,3'd0,3'd0,3'd0}, '{3'd0,3'd0,3'd0,3'd0}, '{3'd0,3'd0,3'd0,3'd0}},
		'{'{3'd0,3'd1,3'd0,3'd0}, '{3'd1,3'd2,3'd0,3'd0}, '{3'd2,3'd0,3'd0,3'd0},
		  '{3'd0,3'd0,3'd0,3'd0}, '{3'd0,3'd0,3'd0,3'd0}, '{3'd0,3'd0,3'd0,3'd0}},
		'{'{3'd0,3'd1,3'd5,3'd4}, '{3'd1,3'd3,3'd7,3'd5}, '{3'd3,3'd2,3'd6,3'd7},
		  '{3'd2,3'd0,3'd4,3'd6}, '{3'd1,3'd0,3'd2,3'd3}, '{3'd4,3'd5,3'd7,3'd6}},
		'{'{3'd0,3'd1,3'd4,3'd3}, '{3'd1,3'd2,3'd5,3'd4}, '{3'd2,3'd0,3'd3,3'd5},
		  '{3'd0,3'd2,3'd1,3'd0}, '{3'd3,3'd4,3'd5,3'd0}, '{3'd0,3'd0,3'd0,3'd0}},
		'{'{3'd1,3'd0,3'd2,3'd0}, '{3'd0,3'd1,3'd3,3'd0}, '{3'd1,3'd2,3'd3,3'd0},
		  '{3'd2,3'd0,3'd3,3'd0}, '{3'd0,3'd0,3'd0,3'd0}, '{3'd0,3'd0,3'd0,3'd0}},
		'{'{3'd0,3'd2,3'd3,3'd1}, '{3'd0,3'd1,3'd4,3'd0}, '{3'd1,3'd3,3'd4,3'd0},
		  '{3'd3,3'd2,3'd4,3'd0}, '{3'd2,3'd0,3'd4,3'd0}, '{3'd0,3'd0,3'd0,3'd0}}
	};

	typedef struct packed {
		logic [2:0]        cell_type;
		logic [CELL_W-1:0] cell_id;
		logic [NODE_W-1:0] node0;
		logic [NODE_W-1:0] node1;
		logic [NODE_W-1:0] node2;
		logic [NODE_W-1:0] node3;
		logic [NODE_W-1:0] node4;
		logic [NODE_W-1:0] node5;
		logic [NODE_W-1:0] node6;
		logic [NODE_W-1:0] node7;
	} cell_t;

	typedef struct packed {
		logic [2:0]        local_face;
		logic [ID_W-1:0]   face_id;
		logic [1:0]        face_kind;
		logic              is_new;
		logic [CELL_W-1:0] neighbor_cell;
		logic              has_neighbor;
		logic              table_full;
		logic              last;
		logic [NODE_W-1:0] face_node0;
		logic [NODE_W-1:0] face_node1;
		logic [NODE_W-1:0] face_node2;
		logic [NODE_W-1:0] face_node3;
	} face_t;

	// one face handed from front to back
	typedef struct packed {
		logic [2:0]             local_face;
		logic [1:0]             kind;
		logic                   last;
		logic [CELL_W-1:0]      owner;
		logic [3:0][NODE_W-1:0] fn;
		logic [3:0][NODE_W-1:0] key;
	} desc_t;

	typedef struct packed {
		logic                   valid;
		logic [1:0]             kind;
		logic [3:0][NODE_W-1:0] key;
		logic [ID_W-1:0]        id;
		logic [CELL_W-1:0]      owner;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [HASH_W-1:0] face_hash(input logic [1:0] kind,
		input logic [3:0][NODE_W-1:0] key);
		logic [FOLD_CHUNKS*HASH_W-1:0] v;
		logic [HASH_W-1:0]             h;
		v = '0;
		v[2+4*NODE_W-1:0] = {kind, key};
		h = '0;
		for (int i = 0; i < FOLD_CHUNKS; i++) begin
			h = h ^ v[i*HASH_W +: HASH_W];
		end
		return h;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mesh_face_matcher_top.sv =====
// channel  | ports                   | handshake
// ---------+-------------------------+----------------------------------
// cell in  | start, busy, mesh_cell  | taken when start high, busy low
// face out | face_valid, face        | one cycle per result, no stall
//
// After reset the face table is cleared, one slot per cycle, with busy
// high. Then a cell is taken; the front emits one face per cycle into a
// four-deep queue while it is not full. The back takes each face through
// IDLE, READ and CHECK, back to READ per extra probe; then pops the next.
// busy stays high while the front still has faces of the cell to queue.
`default_nettype none
module mesh_face_matcher_top
	import mfm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output      logic  busy,
	input  wire cell_t mesh_cell,
	output      logic  face_valid,
	output      face_t face
);
	q_stat_t q_stat;
	desc_t   push_desc;
	desc_t   head_desc;
	logic    push;
	logic    pop;
	logic    active;
	logic    clearing;
	logic    accept;

	assign busy   = active || clearing;
	assign accept = start && !busy;

	mfm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mesh_cell (mesh_cell),
		.q_stat    (q_stat),
		.active    (active),
		.push      (push),
		.desc      (push_desc)
	);

	mfm_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (push_desc),
		.pop     (pop),
		.rd_desc (head_desc),
		.stat    (q_stat)
	);

	mfm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_desc     (head_desc),
		.q_stat     (q_stat),
		.pop        (pop),
		.clearing   (clearing),
		.face_valid (face_valid),
		.face       (face)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/mfm_ram.sv =====
`default_nettype none
module mfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mfm_fifo.sv =====
`default_nettype none
module mfm_fifo
	import mfm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire desc_t   wr_desc,
	input  wire logic    pop,
	output      desc_t   rd_desc,
	output      q_stat_t stat
);
	`include "assert_macros.svh"

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	desc_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    cnt_q;

	assign stat.full  = (cnt_q == (PW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_desc    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_desc;
	end

	`ASSERT_NEVER(a_q_overflow, push && stat.full)
	`ASSERT_NEVER(a_q_underflow, pop && stat.empty)
endmodule
`default_nettype wire

// ===== hw/rtl/mfm_front.sv =====
`default_nettype none
module mfm_front
	import mfm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    accept,
	input  wire cell_t   mesh_cell,
	input  wire q_stat_t q_stat,
	output      logic    active,
	output      logic    push,
	output      desc_t   desc
);
	`include "assert_macros.svh"

	cell_t      cell_q;
	logic       active_q;
	logic [2:0] face_q;

	logic [7:0][NODE_W-1:0] node;
	logic [1:0]             kind;
	logic [2:0]             len;
	logic [3:0][NODE_W-1:0] v;
	logic [1:0]             pos;
	logic [1:0]             left;
	logic [1:0]             right;
	logic                   fwd;
	logic [2:0]             step;
	logic [2:0]             idx;

	assign active = active_q;
	assign push   = active_q && !q_stat.full;
	assign node   = {cell_q.node7, cell_q.node6, cell_q.node5, cell_q.node4,
	                 cell_q.node3, cell_q.node2, cell_q.node1, cell_q.node0};

	always_comb begin
		kind = FACE_KIND_TAB[cell_q.cell_type][face_q];
		unique case (kind)
			KIND_EDGE: len = 3'd2;
			KIND_TRIA: len = 3'd3;
			default:   len = 3'd4;
		endcase
		for (int i = 0; i < 4; i++) begin
			v[i] = (3'(i) < len) ? node[LOCAL_TAB[cell_q.cell_type][face_q][i]] : '0;
		end
		// smallest id, first on ties
		pos = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if ((3'(i) < len) && (v[i] < v[pos])) pos = 2'(i);
		end
		left  = (pos == 2'd0) ? 2'(len - 3'd1) : pos - 2'd1;
		right = ({1'b0, pos} == len - 3'd1) ? 2'd0 : pos + 2'd1;
		fwd   = v[right] < v[left];
		for (int i = 0; i < 4; i++) begin
			step = fwd ? 3'(i) : len - 3'(i);
			idx  = {1'b0, pos} + step;
			if (idx >= len) idx = idx - len;
			desc.key[i] = (3'(i) < len) ? v[idx[1:0]] : '0;
		end
		desc.local_face = face_q;
		desc.kind       = kind;
		desc.last       = (face_q == FACE_TOTAL[cell_q.cell_type] - 3'd1);
		desc.owner      = cell_q.cell_id;
		desc.fn         = v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			face_q   <= '0;
		end else if (accept) begin
			active_q <= (mesh_cell.cell_type <= CT_PYRAMID);
			face_q   <= '0;
		end else if (push) begin
			face_q <= face_q + 3'd1;
			if (desc.last) active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cell_q <= mesh_cell;
	end

	`ASSERT_CLK(a_face_in_range, active_q |-> (face_q < FACE_TOTAL[cell_q.cell_type]))
endmodule
`default_nettype wire

// ===== hw/rtl/mfm_back.sv =====
`default_nettype none
module mfm_back
	import mfm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire desc_t   q_desc,
	input  wire q_stat_t q_stat,
	output      logic    pop,
	output      logic    clearing,
	output      logic    face_valid,
	output      face_t   face
);
	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		BK_CLEAR = 4'b0001,
		BK_IDLE  = 4'b0010,
		BK_READ  = 4'b0100,
		BK_CHECK = 4'b1000
	} bk_state_t;

	localparam int EW = $bits(entry_t);

	bk_state_t         state_q;
	logic [HASH_W-1:0] clr_q;
	logic [HASH_W-1:0] probe_q;
	logic [HASH_W-1:0] tries_q;
	logic [CNT_W-1:0]  count_q;
	desc_t             desc_q;
	face_t             face_q;
	logic              face_valid_q;

	logic              we;
	logic [HASH_W-1:0] waddr;
	entry_t            wentry;
	logic [EW-1:0]     rdata;
	entry_t            rd;
	logic              hit;
	logic              room;
	logic              finish;

	assign pop        = (state_q == BK_IDLE) && !q_stat.empty;
	assign clearing   = (state_q == BK_CLEAR);
	assign face_valid = face_valid_q;
	assign face       = face_q;
	assign rd         = entry_t'(rdata);
	assign hit        = rd.valid && (rd.kind == desc_q.kind) && (rd.key == desc_q.key);
	assign room       = (count_q < CNT_W'(FACE_CAPACITY));
	assign finish     = (state_q == BK_CHECK) && (hit || !rd.valid || (tries_q == '1));

	always_comb begin
		wentry.valid = 1'b1;
		wentry.kind  = desc_q.kind;
		wentry.key   = desc_q.key;
		wentry.id    = count_q[ID_W-1:0];
		wentry.owner = desc_q.owner;
		we    = 1'b0;
		waddr = probe_q;
		if (state_q == BK_CLEAR) begin
			we     = 1'b1;
			waddr  = clr_q;
			wentry = '0;
		end else if ((state_q == BK_CHECK) && !rd.valid && room) begin
			we = 1'b1;
		end
	end

	mfm_ram #(.WIDTH(EW), .DEPTH(HT_DEPTH)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (EW'(wentry)),
		.re    (state_q == BK_READ),
		.raddr (probe_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_CLEAR;
			clr_q        <= '0;
			tries_q      <= '0;
			count_q      <= '0;
			face_valid_q <= 1'b0;
		end else begin
			face_valid_q <= finish;
			unique case (state_q)
				BK_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= BK_IDLE;
				end
				BK_IDLE: begin
					tries_q <= '0;
					if (pop) state_q <= BK_READ;
				end
				BK_READ: state_q <= BK_CHECK;
				BK_CHECK: begin
					if (finish) begin
						state_q <= BK_IDLE;
						if (!hit && !rd.valid && room) count_q <= count_q + 1'b1;
					end else begin
						tries_q <= tries_q + 1'b1;
						state_q <= BK_READ;
					end
				end
				default: state_q <= BK_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q  <= q_desc;
			probe_q <= face_hash(q_desc.kind, q_desc.key);
		end else if ((state_q == BK_CHECK) && !finish) begin
			probe_q <= probe_q + 1'b1;
		end
		if (finish) begin
			face_q.local_face    <= desc_q.local_face;
			face_q.face_kind     <= desc_q.kind;
			face_q.last          <= desc_q.last;
			face_q.face_node0    <= desc_q.fn[0];
			face_q.face_node1    <= desc_q.fn[1];
			face_q.face_node2    <= desc_q.fn[2];
			face_q.face_node3    <= desc_q.fn[3];
			face_q.has_neighbor  <= hit;
			face_q.neighbor_cell <= hit ? rd.owner : '0;
			face_q.is_new        <= !hit && room;
			face_q.table_full    <= !hit && !room;
			face_q.face_id       <= hit ? rd.id : (room ? count_q[ID_W-1:0] : '0);
		end
	end

	`ASSERT_CLK(a_count_bound, count_q <= CNT_W'(FACE_CAPACITY))
	`ASSERT_CLK(a_one_outcome,
		face_valid_q |-> $onehot({face_q.is_new, face_q.has_neighbor, face_q.table_full}))
	`ASSERT_CLK(a_count_step, (count_q != $past(count_q)) |-> $past(finish))
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
	import mfm_pkg::*;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	cell_t mesh_cell = '0;
	logic  busy;
	logic  face_valid;
	face_t face;

	mesh_face_matcher_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mesh_cell  (mesh_cell),
		.face_valid (face_valid),
		.face       (face)
	);

	always #6 clk = ~clk;

	typedef struct {
		cell_t       c;
		bit          typed;
		int          t_id;
		bit          t_new;
		logic [19:0] t_nb;
	} row_t;

	// face table mirror
	int          face_index [logic [2+4*NODE_W-1:0]];
	logic [CELL_W-1:0] face_owner [FACE_CAPACITY];
	int          face_cnt = 0;

	face_t faces_due [$];
	cell_t sent_cells [$];
	row_t  rows [$];
	int    errors = 0;
	int    n_faces = 0, n_hits = 0, n_full = 0, n_items = 0;
	int    idle_pct = 17;

	function automatic logic [NODE_W-1:0] node_of(cell_t c, int i);
		case (i)
			0: return c.node0;
			1: return c.node1;
			2: return c.node2;
			3: return c.node3;
			4: return c.node4;
			5: return c.node5;
			6: return c.node6;
			default: return c.node7;
		endcase
	endfunction

	// v holds the first node in its top slot
	function automatic logic [3:0][NODE_W-1:0] canon_key(logic [3:0][NODE_W-1:0] v, int n);
		logic [3:0][NODE_W-1:0] k;
		logic [NODE_W-1:0]      w [4];
		int p, lft, rgt;
		bit fwd;
		for (int i = 0; i < 4; i++) w[i] = v[3-i];
		p = 0;
		k = '0;
		for (int i = 1; i < n; i++)
			if (w[i] < w[p]) p = i;
		lft = (p == 0) ? n - 1 : p - 1;
		rgt = (p == n - 1) ? 0 : p + 1;
		fwd = w[rgt] < w[lft];
		for (int i = 0; i < n; i++) begin
			k[3-i] = w[p];
			if (fwd) p = (p == n - 1) ? 0 : p + 1;
			else p = (p == 0) ? n - 1 : p - 1;
		end
		return k;
	endfunction

	function automatic void add_row(row_t r);
		rows = {rows, r};
	endfunction

	// walk the faces of one cell, update the mirror, queue the faces due
	task automatic match_cell(cell_t c, ref face_t out [$]);
		int t, nf, len;
		logic [1:0] kind;
		logic [3:0][NODE_W-1:0] fn, k;
		logic [2+4*NODE_W-1:0] tag;
		face_t r;
		t = int'(c.cell_type);
		out = {};
		if (t > 5) return;
		nf = int'(FACE_TOTAL[t]);
		for (int f = 0; f < nf; f++) begin
			kind = FACE_KIND_TAB[t][f];
			len = (kind == KIND_EDGE) ? 2 : (kind == KIND_QUAD) ? 4 : 3;
			fn = '0;
			for (int i = 0; i < len; i++) fn[3-i] = node_of(c, int'(LOCAL_TAB[t][f][i]));
			k = canon_key(fn, len);
			tag = {kind, k};
			r = '0;
			r.local_face = 3'(f);
			r.face_kind = kind;
			r.last = (f == nf - 1);
			{r.face_node0, r.face_node1, r.face_node2, r.face_node3} = fn;
			if (face_index.exists(tag)) begin
				r.face_id = ID_W'(face_index[tag]);
				r.neighbor_cell = face_owner[face_index[tag]];
				r.has_neighbor = 1'b1;
			end else if (face_cnt < FACE_CAPACITY) begin
				face_index[tag] = face_cnt;
				face_owner[face_cnt] = c.cell_id;
				r.face_id = ID_W'(face_cnt);
				r.is_new = 1'b1;
				face_cnt++;
			end else begin
				r.table_full = 1'b1;
			end
			out = {out, r};
		end
	endtask

	task automatic send_cell(cell_t c, row_t row, bit use_row);
		face_t due [$];
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		mesh_cell <= c;
		do @(posedge clk); while (busy);
		match_cell(c, due);
		if (use_row && row.typed && due.size() > 0) begin
			due[0].face_id = ID_W'(row.t_id);
			due[0].is_new = row.t_new;
			due[0].has_neighbor = !row.t_new;
			due[0].neighbor_cell = row.t_nb;
		end
		foreach (due[i]) faces_due = {faces_due, due[i]};
		sent_cells = {sent_cells, c};
		n_items++;
	endtask

	task automatic chk(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		face_t e;
		if (arst_n && face_valid) begin
			if (faces_due.size() == 0) begin
				$display("%0t unexpected face: expected none actual %h", $time, face);
				errors++;
			end else begin
				e = faces_due.pop_front();
				chk("local_face", e.local_face, face.local_face);
				chk("face_id", e.face_id, face.face_id);
				chk("face_kind", e.face_kind, face.face_kind);
				chk("is_new", e.is_new, face.is_new);
				chk("neighbor_cell", e.neighbor_cell, face.neighbor_cell);
				chk("has_neighbor", e.has_neighbor, face.has_neighbor);
				chk("table_full", e.table_full, face.table_full);
				chk("last", e.last, face.last);
				chk("face_node0", e.face_node0, face.face_node0);
				chk("face_node1", e.face_node1, face.face_node1);
				chk("face_node2", e.face_node2, face.face_node2);
				chk("face_node3", e.face_node3, face.face_node3);
				n_faces++;
				n_hits += face.has_neighbor;
				n_full += face.table_full;
			end
		end
	end

	function automatic cell_t mk(int t, int id, int n0, int n1, int n2, int n3,
		int n4, int n5, int n6, int n7);
		cell_t c;
		c.cell_type = 3'(t);
		c.cell_id = CELL_W'(id);
		{c.node0, c.node1, c.node2, c.node3} = {n0[19:0], n1[19:0], n2[19:0], n3[19:0]};
		{c.node4, c.node5, c.node6, c.node7} = {n4[19:0], n5[19:0], n6[19:0], n7[19:0]};
		return c;
	endfunction

	function automatic row_t row(cell_t c, bit typed = 0, int id = 0, bit nw = 0,
		int nb = 0);
		row_t r;
		r.c = c;
		r.typed = typed;
		r.t_id = id;
		r.t_new = nw;
		r.t_nb = nb[19:0];
		return r;
	endfunction

	function automatic cell_t rand_cell(int pool);
		cell_t c;
		c.cell_type = 3'($urandom_range(99) < 5 ? $urandom_range(7, 6) : $urandom_range(5));
		c.cell_id = CELL_W'($urandom);
		c.node0 = NODE_W'(pool ? $urandom_range(pool) : $urandom);
		c.node1 = NODE_W'(pool ? $urandom_range(pool) : $urandom);
		c.node2 = NODE_W'(pool ? $urandom_range(pool) : $urandom);
		c.node3 = NODE_W'(pool ? $urandom_range(pool) : $urandom);
		c.node4 = NODE_W'(pool ? $urandom_range(pool) : $urandom);
		c.node5 = NODE_W'(pool ? $urandom_range(pool) : $urandom);
		c.node6 = NODE_W'(pool ? $urandom_range(pool) : $urandom);
		c.node7 = NODE_W'(pool ? $urandom_range(pool) : $urandom);
		return c;
	endfunction

	initial begin
		cell_t c;
		int    wait_cnt;
		add_row(row(mk(0, 7, 1, 2, 3, 4, 0, 0, 0, 0), 1, 0, 1, 0));
		add_row(row(mk(0, 8, 1, 2, 3, 4, 0, 0, 0, 0), 1, 0, 0, 7));
		add_row(row(mk(0, 9, 4, 3, 2, 1, 9, 9, 9, 9)));
		add_row(row(mk(1, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF,
			'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF)));
		add_row(row(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
		add_row(row(mk(2, 20, 0, 1, 2, 3, 4, 5, 6, 7)));
		add_row(row(mk(2, 21, 4, 5, 6, 7, 8, 9, 10, 11)));
		add_row(row(mk(2, 22, 'hFFFFF, 'hFFFFE, 'hFFFFD, 'hFFFFC,
			'hFFFFB, 'hFFFFA, 'hFFFF9, 'hFFFF8)));
		add_row(row(mk(3, 30, 0, 1, 2, 4, 5, 6, 0, 0)));
		add_row(row(mk(3, 31, 4, 5, 6, 8, 9, 10, 0, 0)));
		add_row(row(mk(4, 40, 0, 1, 2, 3, 0, 0, 0, 0)));
		add_row(row(mk(4, 41, 3, 2, 1, 0, 0, 0, 0, 0)));
		add_row(row(mk(5, 50, 0, 1, 2, 3, 12, 0, 0, 0)));
		add_row(row(mk(5, 51, 5, 5, 5, 5, 5, 0, 0, 0)));
		add_row(row(mk(6, 60, 1, 2, 3, 4, 5, 6, 7, 8)));
		add_row(row(mk(7, 'hFFFFF, 1, 2, 3, 4, 5, 6, 7, 8)));
		add_row(row(mk(3, 'hAAAAA, 'h55555, 'hAAAAA, 'h0F0F0, 'hF0F0F,
			'h12345, 'hEDCBA, 0, 0)));

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) send_cell(rows[i].c, rows[i], 1);

		for (int i = 0; i < 263; i++) begin
			idle_pct = (i < 88) ? 17 : (i < 176) ? 64 : 0;
			case ($urandom_range(9))
				0: c = rand_cell(0);
				1, 2, 3: begin
					c = sent_cells[$urandom_range(sent_cells.size() - 1)];
					c.cell_id = CELL_W'($urandom);
				end
				default: c = rand_cell($urandom_range(1) ? 12 : 40);
			endcase
			send_cell(c, rows[0], 0);
		end
		@(negedge clk);
		start <= 1'b0;

		wait_cnt = 0;
		while (faces_due.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (60) @(posedge clk);
		$display("%0d cells taken, %0d faces checked: %0d matched, %0d refused by full table",
			n_items, n_faces, n_hits, n_full);
		if (errors == 0 && faces_due.size() == 0) begin
			$display("** mesh_face_matcher_top: PASSED **");
		end else begin
			$display("%0d errors, %0d faces never seen", errors, faces_due.size());
			$display("** mesh_face_matcher_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#(12 * 2000000);
		$display("timeout");
		$display("** mesh_face_matcher_top: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mfm_pkg.sv
hw/rtl/mfm_ram.sv
hw/rtl/mfm_fifo.sv
hw/rtl/mfm_front.sv
hw/rtl/mfm_back.sv
hw/rtl/mesh_face_matcher_top.sv
dv/tb.sv
